>>> rtl/fct_pkg.sv
// Package for the flux-corrected transport smoother.
// Holds the widths, payload and control types, the sequencer states and the
// saturation helper shared by the scaler, the sequencer and the top level.
`default_nettype none

package fct_pkg;

  localparam int unsigned SampleWidth  = 32;
  localparam int unsigned GainWidth    = 16;
  localparam int unsigned CountWidth   = 3;
  localparam int unsigned PaddrWidth   = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned WinDepth     = 5;
  localparam int unsigned HistDepth    = 3;

  localparam logic [GainWidth-1:0]  GainReset = GainWidth'(8192);
  localparam logic [CountWidth-1:0] CountSat  = CountWidth'(6);

  // Register index, taken from the word address of the configuration port.
  localparam logic RegIdxGain = 1'b0;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [SampleWidth:0]   diff_t;
  typedef logic signed [SampleWidth+1:0] wide_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_item_t;

  typedef struct packed {
    sample_t smoothed;
    logic    last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StTScale1,
    StTWait1,
    StTScale2,
    StTWait2,
    StLoad,
    StDiff,
    StWait,
    StLim1,
    StLim2,
    StLim3,
    StFlux,
    StEmit,
    StPass0,
    StPass1,
    StUpdate
  } state_e;

  typedef enum logic [1:0] {
    KindInterior,
    KindFirst,
    KindEnd,
    KindTail
  } kind_e;

  typedef enum logic [1:0] {
    OpNewDiff,
    OpOldDiff,
    OpWinDiff
  } scale_op_e;

  typedef enum logic [1:0] {
    EmitFlux,
    EmitRaw,
    EmitSample
  } emit_sel_e;

  typedef struct packed {
    logic      idle;
    logic      accept;
    logic      scale_start;
    scale_op_e scale_op;
    logic      part_load;
    logic      t_load;
    logic      win_load;
    logic      win_skip;
    logic      diff_load;
    logic      lim1;
    logic      lim2;
    logic      lim3;
    logic      flux_load;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    kind_e     kind;
    logic      update;
  } ctrl_t;

  typedef struct packed {
    logic                  in_valid;
    logic                  in_last;
    logic                  item_last;
    logic [CountWidth-1:0] count;
    logic                  scale_done;
    logic                  out_free;
  } status_t;

  // Clamp a value two bits wider than a sample to the signed sample range.
  function automatic sample_t sat_wide(input wide_t v);
    sample_t r;
    if (v[SampleWidth+1:SampleWidth-1] == 3'b000 ||
        v[SampleWidth+1:SampleWidth-1] == 3'b111) begin
      r = v[SampleWidth-1:0];
    end else if (v[SampleWidth+1]) begin
      r = {1'b1, {(SampleWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(SampleWidth-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fct_scale.sv
// Shared four-stage scaler: rounds |v|*mu/65536 half away from zero,
// restores the sign and saturates to the sample range.
// Depends on fct_pkg for widths, types and the saturation helper.
`default_nettype none

module fct_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  fct_pkg::diff_t                  operand_i,
  input  logic [fct_pkg::GainWidth-1:0]   gain_i,
  output logic                            done_o,
  output fct_pkg::sample_t                result_o
);

  localparam int unsigned MagWidth  = fct_pkg::SampleWidth + 1;
  localparam int unsigned ProdWidth = MagWidth + fct_pkg::GainWidth;
  localparam logic [ProdWidth-1:0] RoundBias = ProdWidth'(1) << (fct_pkg::GainWidth - 1);

  logic [3:0]             vld_q;
  fct_pkg::diff_t         op_q;
  logic                   neg_q;
  logic [MagWidth-1:0]    mag_q;
  logic [MagWidth-1:0]    mag_d;
  logic                   neg2_q;
  logic [ProdWidth-1:0]   prod_q;
  logic [ProdWidth-1:0]   prod_d;
  logic [MagWidth-1:0]    quot;
  fct_pkg::wide_t         signed_d;
  fct_pkg::sample_t       res_q;

  always_comb begin
    mag_d    = op_q[fct_pkg::SampleWidth] ? (~op_q + 1'b1) : op_q;
    prod_d   = mag_q * gain_i;
    prod_d   = prod_d + RoundBias;
    quot     = prod_q[ProdWidth-1:fct_pkg::GainWidth];
    signed_d = neg2_q ? -fct_pkg::wide_t'({1'b0, quot}) : fct_pkg::wide_t'({1'b0, quot});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= operand_i;
    end
    neg_q  <= op_q[fct_pkg::SampleWidth];
    mag_q  <= mag_d;
    neg2_q <= neg_q;
    prod_q <= prod_d;
    res_q  <= fct_pkg::sat_wide(signed_d);
  end

  assign done_o   = vld_q[3];
  assign result_o = res_q;

endmodule

`default_nettype wire

>>> rtl/fct_seq.sv
// Sequencer of the smoother: steps one item through the diffusion, the
// limiter passes and the result emits, one scaler job at a time.
// Depends on fct_pkg for the state, control and status types.
`default_nettype none

module fct_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fct_pkg::status_t status_i,
  output fct_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned RelWidth = 3;
  localparam logic [RelWidth-1:0] RelFirst = RelWidth'(1);
  localparam logic [RelWidth-1:0] RelSecond = RelWidth'(2);
  localparam logic [RelWidth-1:0] RelEnd = RelWidth'(3);
  localparam logic [RelWidth-1:0] RelTail = RelWidth'(4);

  fct_pkg::state_e       state_q, state_d;
  logic [RelWidth-1:0]   rel_q, rel_d;
  fct_pkg::kind_e        kind;
  logic                  all_done;
  logic                  short_vec;
  logic                  has_t;

  // Position of the current result within the five-sample window decides
  // which limits apply.
  always_comb begin
    if (status_i.item_last && rel_q == RelTail) begin
      kind = fct_pkg::KindTail;
    end else if ((status_i.count == fct_pkg::CountWidth'(3) && rel_q == RelFirst) ||
                 (status_i.count == fct_pkg::CountWidth'(2) && rel_q == RelSecond)) begin
      kind = fct_pkg::KindFirst;
    end else if (status_i.item_last && rel_q == RelEnd) begin
      kind = fct_pkg::KindEnd;
    end else begin
      kind = fct_pkg::KindInterior;
    end
  end

  assign all_done  = status_i.item_last ? (rel_q == RelTail) : (rel_q == RelFirst);
  assign short_vec = status_i.count < fct_pkg::CountWidth'(2);
  assign has_t     = status_i.count >= fct_pkg::CountWidth'(2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fct_pkg::StIdle: begin
        if (status_i.in_valid) begin
          if (status_i.in_last && short_vec) begin
            state_d = (status_i.count == fct_pkg::CountWidth'(1)) ?
                      fct_pkg::StPass0 : fct_pkg::StPass1;
          end else if (has_t) begin
            state_d = fct_pkg::StTScale1;
          end else begin
            state_d = fct_pkg::StLoad;
          end
        end
      end
      fct_pkg::StTScale1: state_d = fct_pkg::StTWait1;
      fct_pkg::StTWait1: begin
        if (status_i.scale_done) begin
          state_d = fct_pkg::StTScale2;
        end
      end
      fct_pkg::StTScale2: state_d = fct_pkg::StTWait2;
      fct_pkg::StTWait2: begin
        if (status_i.scale_done) begin
          state_d = fct_pkg::StLoad;
        end
      end
      fct_pkg::StLoad: begin
        if (status_i.item_last || status_i.count >= fct_pkg::CountWidth'(3)) begin
          state_d = fct_pkg::StDiff;
        end else begin
          state_d = fct_pkg::StUpdate;
        end
      end
      fct_pkg::StDiff: begin
        state_d = (kind == fct_pkg::KindTail) ? fct_pkg::StFlux : fct_pkg::StWait;
      end
      fct_pkg::StWait: begin
        if (status_i.scale_done) begin
          state_d = fct_pkg::StLim1;
        end
      end
      fct_pkg::StLim1: state_d = fct_pkg::StLim2;
      fct_pkg::StLim2: state_d = fct_pkg::StLim3;
      fct_pkg::StLim3: state_d = fct_pkg::StFlux;
      fct_pkg::StFlux: state_d = fct_pkg::StEmit;
      fct_pkg::StEmit: begin
        if (status_i.out_free) begin
          state_d = all_done ? fct_pkg::StUpdate : fct_pkg::StDiff;
        end
      end
      fct_pkg::StPass0: begin
        if (status_i.out_free) begin
          state_d = fct_pkg::StPass1;
        end
      end
      fct_pkg::StPass1: begin
        if (status_i.out_free) begin
          state_d = fct_pkg::StUpdate;
        end
      end
      fct_pkg::StUpdate: state_d = fct_pkg::StIdle;
      default: state_d = fct_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o             = '0;
    ctrl_o.scale_op    = fct_pkg::OpWinDiff;
    ctrl_o.emit_sel    = fct_pkg::EmitFlux;
    ctrl_o.kind        = kind;
    rel_d              = rel_q;
    unique case (state_q)
      fct_pkg::StIdle: begin
        ctrl_o.idle   = 1'b1;
        ctrl_o.accept = status_i.in_valid;
      end
      fct_pkg::StTScale1: begin
        ctrl_o.scale_start = 1'b1;
        ctrl_o.scale_op    = fct_pkg::OpNewDiff;
      end
      fct_pkg::StTWait1: ctrl_o.part_load = status_i.scale_done;
      fct_pkg::StTScale2: begin
        ctrl_o.scale_start = 1'b1;
        ctrl_o.scale_op    = fct_pkg::OpOldDiff;
      end
      fct_pkg::StTWait2: ctrl_o.t_load = status_i.scale_done;
      fct_pkg::StLoad: begin
        ctrl_o.win_load = 1'b1;
        // A three-sample vector starts one position further into the window.
        ctrl_o.win_skip = status_i.item_last && status_i.count == fct_pkg::CountWidth'(2);
        rel_d = ctrl_o.win_skip ? RelSecond : RelFirst;
      end
      fct_pkg::StDiff: begin
        ctrl_o.scale_start = (kind != fct_pkg::KindTail);
        ctrl_o.diff_load   = 1'b1;
      end
      fct_pkg::StWait: ;
      fct_pkg::StLim1: ctrl_o.lim1 = 1'b1;
      fct_pkg::StLim2: ctrl_o.lim2 = 1'b1;
      fct_pkg::StLim3: ctrl_o.lim3 = 1'b1;
      fct_pkg::StFlux: ctrl_o.flux_load = 1'b1;
      fct_pkg::StEmit: begin
        ctrl_o.emit      = status_i.out_free;
        ctrl_o.emit_last = (kind == fct_pkg::KindTail);
        if (status_i.out_free) begin
          rel_d = rel_q + RelWidth'(1);
        end
      end
      fct_pkg::StPass0: begin
        ctrl_o.emit     = status_i.out_free;
        ctrl_o.emit_sel = fct_pkg::EmitRaw;
      end
      fct_pkg::StPass1: begin
        ctrl_o.emit      = status_i.out_free;
        ctrl_o.emit_sel  = fct_pkg::EmitSample;
        ctrl_o.emit_last = 1'b1;
      end
      fct_pkg::StUpdate: ctrl_o.update = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fct_pkg::StIdle;
      rel_q   <= '0;
    end else begin
      state_q <= state_d;
      rel_q   <= rel_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fct_diffuse_antidiffuse_smoother.sv
// Top level of the flux-corrected transport smoother with the limiter.
// Depends on fct_pkg, fct_scale (shared scaler) and fct_seq (sequencer).
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    fct_pkg::in_item_t
// out      output     out_valid_o / out_stall_i  fct_pkg::out_item_t
// cfg      input      psel, penable, pwrite      smoothing_gain at byte address 0
//
// One item is taken at a time. The four-stage scaler is the shared unit, used
// twice for the diffused sample and once per limited flux. An item also waits
// for as long as the output is stalled while a result waits.
// Reset clears the vector state and loads the gain with its default; there is
// no clearing pass. in_stall_o is high whenever an item is in progress.
`default_nettype none

module fct_diffuse_antidiffuse_smoother (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fct_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fct_pkg::out_item_t                  out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fct_pkg::PaddrWidth-1:0]      paddr,
  input  logic [fct_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [fct_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned Msb = fct_pkg::SampleWidth - 1;

  fct_pkg::ctrl_t                     ctrl;
  fct_pkg::status_t                   status;

  logic [fct_pkg::GainWidth-1:0]      gain_q;
  logic [fct_pkg::CountWidth-1:0]     count_q;
  fct_pkg::sample_t                   raw0_q, raw1_q;
  fct_pkg::sample_t                   dw_q [fct_pkg::HistDepth];
  fct_pkg::sample_t                   prev_q;
  fct_pkg::sample_t                   x_q;
  logic                               last_q;
  fct_pkg::diff_t                     part_q, part_d;
  fct_pkg::sample_t                   t_q, t_d, t_sel;
  fct_pkg::sample_t                   win_q [fct_pkg::WinDepth];
  fct_pkg::sample_t                   win_d [fct_pkg::WinDepth];
  fct_pkg::sample_t                   win_arr [fct_pkg::WinDepth];
  fct_pkg::diff_t                     dr_q, dl_q;
  logic                               sgn_q, sgn_d;
  fct_pkg::wide_t                     mag_q, mag_d;
  fct_pkg::wide_t                     sr_q, sr_d, sl_q, sl_d;
  fct_pkg::wide_t                     c_q, c2_d, c3_d, m3;
  fct_pkg::wide_t                     neg_c;
  fct_pkg::sample_t                   fm_q, fm_d;
  fct_pkg::diff_t                     sum_q, sum_d;
  fct_pkg::sample_t                   emit_val;
  logic                               out_valid_q;
  fct_pkg::out_item_t                 out_item_q;
  logic                               out_free;
  logic                               cfg_we;

  fct_pkg::diff_t                     scale_opnd;
  logic                               scale_done;
  fct_pkg::sample_t                   scale_res;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = (paddr[fct_pkg::PaddrWidth-1] == fct_pkg::RegIdxGain) ?
                  fct_pkg::ApbDataWidth'(gain_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= fct_pkg::GainReset;
    end else if (cfg_we && paddr[fct_pkg::PaddrWidth-1] == fct_pkg::RegIdxGain) begin
      gain_q <= pwdata[fct_pkg::GainWidth-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status.in_valid   = in_valid_i;
  assign status.in_last    = in_item_i.last_sample;
  assign status.item_last  = last_q;
  assign status.count      = count_q;
  assign status.scale_done = scale_done;
  assign status.out_free   = out_free;

  fct_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  always_comb begin
    case (ctrl.scale_op)
      fct_pkg::OpNewDiff: scale_opnd = fct_pkg::diff_t'(x_q) - fct_pkg::diff_t'(raw0_q);
      fct_pkg::OpOldDiff: scale_opnd = fct_pkg::diff_t'(raw0_q) - fct_pkg::diff_t'(raw1_q);
      default:            scale_opnd = fct_pkg::diff_t'(win_q[2]) - fct_pkg::diff_t'(win_q[1]);
    endcase
  end

  fct_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.scale_start),
    .operand_i (scale_opnd),
    .gain_i    (gain_q),
    .done_o    (scale_done),
    .result_o  (scale_res)
  );

  // Diffused sample: raw0 + mu*(x - raw0) - mu*(raw0 - raw1), saturated.
  assign part_d = fct_pkg::diff_t'(raw0_q) + fct_pkg::diff_t'(scale_res);
  assign t_d    = fct_pkg::sat_wide(fct_pkg::wide_t'(part_q) - fct_pkg::wide_t'(scale_res));

  always_comb begin
    if (count_q >= fct_pkg::CountWidth'(2)) begin
      t_sel = t_q;
    end else if (count_q == fct_pkg::CountWidth'(1)) begin
      t_sel = raw0_q;
    end else begin
      t_sel = '0;
    end
    win_arr[0] = dw_q[2];
    win_arr[1] = dw_q[1];
    win_arr[2] = dw_q[0];
    win_arr[3] = t_sel;
    win_arr[4] = x_q;
  end

  // Working window; it slides by one after each result so the taps stay fixed.
  always_comb begin
    win_d = win_q;
    if (ctrl.win_load) begin
      for (int i = 0; i < fct_pkg::WinDepth - 1; i++) begin
        win_d[i] = ctrl.win_skip ? win_arr[i+1] : win_arr[i];
      end
      win_d[fct_pkg::WinDepth-1] = ctrl.win_skip ? '0 : win_arr[fct_pkg::WinDepth-1];
    end else if (ctrl.emit && ctrl.emit_sel == fct_pkg::EmitFlux) begin
      for (int i = 0; i < fct_pkg::WinDepth - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[fct_pkg::WinDepth-1] = '0;
    end
  end

  // Limiter: min(|f|, s*right, s*left), clamped at zero, sign restored.
  always_comb begin
    sgn_d = !scale_res[Msb];
    mag_d = sgn_d ? fct_pkg::wide_t'(scale_res) : -fct_pkg::wide_t'(scale_res);
    sr_d  = sgn_d ? fct_pkg::wide_t'(dr_q) : -fct_pkg::wide_t'(dr_q);
    sl_d  = sgn_d ? fct_pkg::wide_t'(dl_q) : -fct_pkg::wide_t'(dl_q);
    c2_d  = (ctrl.kind != fct_pkg::KindEnd && sr_q < mag_q) ? sr_q : mag_q;
    m3    = (ctrl.kind != fct_pkg::KindFirst && sl_q < c_q) ? sl_q : c_q;
    c3_d  = m3[fct_pkg::SampleWidth+1] ? '0 : m3;
    neg_c = -c_q;
    if (ctrl.kind == fct_pkg::KindTail) begin
      fm_d = '0;
    end else begin
      fm_d = sgn_q ? c_q[Msb:0] : neg_c[Msb:0];
    end
    sum_d = fct_pkg::diff_t'(win_q[1]) + fct_pkg::diff_t'(prev_q);
  end

  always_comb begin
    case (ctrl.emit_sel)
      fct_pkg::EmitRaw:    emit_val = raw0_q;
      fct_pkg::EmitSample: emit_val = x_q;
      default: begin
        if (ctrl.kind == fct_pkg::KindFirst) begin
          emit_val = win_q[1];
        end else begin
          emit_val = fct_pkg::sat_wide(fct_pkg::wide_t'(sum_q) - fct_pkg::wide_t'(fm_q));
        end
      end
    endcase
  end

  // Vector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      raw0_q  <= '0;
      raw1_q  <= '0;
      prev_q  <= '0;
      for (int i = 0; i < fct_pkg::HistDepth; i++) begin
        dw_q[i] <= '0;
      end
    end else begin
      if (ctrl.emit && ctrl.emit_sel == fct_pkg::EmitFlux) begin
        prev_q <= fm_q;
      end
      if (ctrl.update) begin
        if (last_q) begin
          count_q <= '0;
          raw0_q  <= '0;
          raw1_q  <= '0;
          prev_q  <= '0;
          for (int i = 0; i < fct_pkg::HistDepth; i++) begin
            dw_q[i] <= '0;
          end
        end else begin
          if (count_q != '0) begin
            dw_q[2] <= dw_q[1];
            dw_q[1] <= dw_q[0];
            dw_q[0] <= t_q;
          end
          raw1_q <= raw0_q;
          raw0_q <= x_q;
          if (count_q < fct_pkg::CountSat) begin
            count_q <= count_q + fct_pkg::CountWidth'(1);
          end
        end
      end
    end
  end

  // Working registers of the item in progress.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      x_q    <= in_item_i.sample;
      last_q <= in_item_i.last_sample;
    end
    if (ctrl.part_load) begin
      part_q <= part_d;
    end
    if (ctrl.t_load) begin
      t_q <= t_d;
    end else if (ctrl.win_load) begin
      t_q <= t_sel;
    end
    win_q <= win_d;
    if (ctrl.diff_load) begin
      dr_q <= fct_pkg::diff_t'(win_q[3]) - fct_pkg::diff_t'(win_q[2]);
      dl_q <= fct_pkg::diff_t'(win_q[1]) - fct_pkg::diff_t'(win_q[0]);
    end
    if (ctrl.lim1) begin
      sgn_q <= sgn_d;
      mag_q <= mag_d;
      sr_q  <= sr_d;
      sl_q  <= sl_d;
    end
    if (ctrl.lim2) begin
      c_q <= c2_d;
    end else if (ctrl.lim3) begin
      c_q <= c3_d;
    end
    if (ctrl.flux_load) begin
      fm_q  <= fm_d;
      sum_q <= sum_d;
    end
    if (ctrl.emit) begin
      out_item_q.smoothed    <= emit_val;
      out_item_q.last_result <= ctrl.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = !ctrl.idle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
